// File: rtl/lik_pkg.sv
// Shared types, widths and constants of the leg inverse kinematics core.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lik_pkg;

   // field and datapath widths
   localparam int POS_W      = 20;
   localparam int LINK_W     = 18;
   localparam int SQ_W       = 39;
   localparam int SUMSQ_W    = 40;
   localparam int ROOT_W     = 20;
   localparam int DIST_W     = 19;
   localparam int NUM_W      = 40;
   localparam int DEN_W      = 38;
   localparam int COS_W      = 18;
   localparam int CORD_W     = 45;
   localparam int TQ_W       = 34;
   localparam int ATAN_IN_W  = 21;
   localparam int YAW_W      = 19;
   localparam int HIP_W      = 20;
   localparam int KNEE_W     = 18;
   localparam int CORDIC_STEPS = 30;
   localparam int DIV_STEPS  = 16;
   localparam int ROOT_STEPS = 20;

   // short queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // alignment delays inside the back pipeline
   localparam int Z_DLY     = 20;
   localparam int COS_DLY   = 22;
   localparam int ALPHA_DLY = 43;
   localparam int YAW_DLY   = 63;
   localparam int VALID_DLY = 98;

   localparam logic signed [TQ_W-1:0]  PI_Q30      = 34'sd3373259426;
   localparam logic signed [TQ_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [HIP_W-1:0] PI_F        = 20'sd205887;
   localparam logic [LINK_W-1:0]       LINK_RESET  = 18'd6554;

   // register indexes
   localparam logic REG_UPPER = 1'b0;
   localparam logic REG_LOWER = 1'b1;

   typedef enum logic [1:0] {
      KIND_NORMAL,
      KIND_Y_ZERO,
      KIND_X_ZERO
   } atan_kind_type;

   typedef struct packed {
      logic          x_neg;
      logic          y_neg;
      atan_kind_type kind;
   } atan_flags_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [SUMSQ_W-1:0]      rsq;
      logic [SUMSQ_W-1:0]      dsq;
   } entry_type;

   // arctangent of 2^-i in Q.30
   function automatic logic signed [TQ_W-1:0] atan_q30(input int idx);
      logic signed [TQ_W-1:0] v;
      case (idx)
         0:       v = 34'sd843314857;
         1:       v = 34'sd497837829;
         2:       v = 34'sd263043837;
         3:       v = 34'sd133525159;
         4:       v = 34'sd67021687;
         5:       v = 34'sd33543516;
         6:       v = 34'sd16775851;
         7:       v = 34'sd8388437;
         8:       v = 34'sd4194283;
         9:       v = 34'sd2097149;
         default: v = 34'sd1 <<< (30 - idx);
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: rtl/lik_sqrt.sv
// Pipelined floor square root, one result bit per stage.
// Depends on lik_pkg.
`default_nettype none

module lik_sqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [lik_pkg::SUMSQ_W-1:0]  radicand,
   output logic [lik_pkg::ROOT_W-1:0]   root
);

   logic [21:0]                        rem_ff  [0:lik_pkg::ROOT_STEPS-1];
   logic [21:0]                        rem_in  [0:lik_pkg::ROOT_STEPS-1];
   logic [lik_pkg::ROOT_W-1:0]         root_ff [0:lik_pkg::ROOT_STEPS-1];
   logic [lik_pkg::ROOT_W-1:0]         root_in [0:lik_pkg::ROOT_STEPS-1];
   logic [lik_pkg::SUMSQ_W-1:0]        rad_ff  [0:lik_pkg::ROOT_STEPS-1];
   logic [lik_pkg::SUMSQ_W-1:0]        rad_in  [0:lik_pkg::ROOT_STEPS-1];

   // one digit pair per stage: bring down two bits, try 4R+1
   always_comb begin
      logic [21:0]                 rem_src;
      logic [lik_pkg::ROOT_W-1:0]  root_src;
      logic [lik_pkg::SUMSQ_W-1:0] rad_src;
      logic [23:0]                 cat;
      logic [23:0]                 trial;
      for (int k = 0; k < lik_pkg::ROOT_STEPS; k++) begin
         if (k == 0) begin
            rem_src  = '0;
            root_src = '0;
            rad_src  = radicand;
         end else begin
            rem_src  = rem_ff[k-1];
            root_src = root_ff[k-1];
            rad_src  = rad_ff[k-1];
         end
         cat   = {rem_src, rad_src[39:38]};
         trial = {2'b00, root_src, 2'b01};
         if (cat >= trial) begin
            rem_in[k]  = 22'(cat - trial);
            root_in[k] = {root_src[18:0], 1'b1};
         end else begin
            rem_in[k]  = cat[21:0];
            root_in[k] = {root_src[18:0], 1'b0};
         end
         rad_in[k] = {rad_src[37:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < lik_pkg::ROOT_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
         end
      end
   end

   assign root = root_ff[lik_pkg::ROOT_STEPS-1];

endmodule

`default_nettype wire

// File: rtl/lik_divider.sv
// Pipelined saturating cosine divider: sign(num) * min(1, |num|/den) in Q.16.
// Depends on lik_pkg.
`default_nettype none

module lik_divider (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [lik_pkg::NUM_W-1:0]  num,
   input  logic [lik_pkg::DEN_W-1:0]         den,
   output logic signed [lik_pkg::COS_W-1:0]  quot
);

   localparam int N = lik_pkg::DIV_STEPS;

   logic [lik_pkg::DEN_W-1:0] rem_ff [0:N];
   logic [lik_pkg::DEN_W-1:0] rem_in [0:N];
   logic [lik_pkg::DEN_W-1:0] den_ff [0:N];
   logic [15:0]               q_ff   [0:N];
   logic [15:0]               q_in   [0:N];
   logic                      neg_ff [0:N];
   logic                      sat_ff [0:N];
   logic [lik_pkg::NUM_W-1:0] mag;
   logic                      sat_in;
   logic signed [lik_pkg::COS_W-1:0] quot_ff;
   logic signed [lik_pkg::COS_W-1:0] quot_in;
   logic [16:0]               qmag;

   // magnitude and saturation check
   always_comb begin
      mag    = num[lik_pkg::NUM_W-1] ? lik_pkg::NUM_W'(-num) : lik_pkg::NUM_W'(num);
      sat_in = mag >= {2'b00, den};
   end

   // restoring steps, one quotient bit each
   always_comb begin
      logic [lik_pkg::DEN_W:0] r2;
      rem_in[0] = mag[lik_pkg::DEN_W-1:0];
      q_in[0]   = '0;
      for (int k = 0; k < N; k++) begin
         r2 = {rem_ff[k], 1'b0};
         if (r2 >= {1'b0, den_ff[k]}) begin
            rem_in[k+1] = lik_pkg::DEN_W'(r2 - {1'b0, den_ff[k]});
            q_in[k+1]   = {q_ff[k][14:0], 1'b1};
         end else begin
            rem_in[k+1] = r2[lik_pkg::DEN_W-1:0];
            q_in[k+1]   = {q_ff[k][14:0], 1'b0};
         end
      end
   end

   // apply saturation and sign
   always_comb begin
      qmag    = sat_ff[N] ? 17'h10000 : {1'b0, q_ff[N]};
      quot_in = neg_ff[N] ? -lik_pkg::COS_W'(qmag) : lik_pkg::COS_W'(qmag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         den_ff[0] <= den;
         neg_ff[0] <= num[lik_pkg::NUM_W-1];
         sat_ff[0] <= sat_in;
         for (int k = 0; k < N; k++) begin
            rem_ff[k+1] <= rem_in[k+1];
            q_ff[k+1]   <= q_in[k+1];
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            sat_ff[k+1] <= sat_ff[k];
         end
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

// File: rtl/lik_atan2.sv
// Pipelined four-quadrant arctangent: normalise, 30 CORDIC vectoring stages,
// clamp, reflect and round to Q.16. Depends on lik_pkg.
`default_nettype none

module lik_atan2 (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [lik_pkg::ATAN_IN_W-1:0] y_val,
   input  logic signed [lik_pkg::ATAN_IN_W-1:0] x_val,
   output logic signed [lik_pkg::YAW_W-1:0]     angle
);

   localparam int N = lik_pkg::CORDIC_STEPS;
   localparam int W = lik_pkg::ATAN_IN_W;

   logic [W-1:0]                  ax_in, ay_in, ax0_ff, ay0_ff, ax1_ff, ay1_ff, m;
   lik_pkg::atan_flags_type       fl_in, fl0_ff, fl1_ff;
   logic [5:0]                    sh_in, sh1_ff;
   logic [61:0]                   wide_x, wide_y;
   logic signed [lik_pkg::CORD_W-1:0] cx_ff [0:N];
   logic signed [lik_pkg::CORD_W-1:0] cy_ff [0:N];
   logic signed [lik_pkg::CORD_W-1:0] cx_in [0:N];
   logic signed [lik_pkg::CORD_W-1:0] cy_in [0:N];
   logic signed [lik_pkg::TQ_W-1:0]   t_ff  [0:N];
   logic signed [lik_pkg::TQ_W-1:0]   t_in  [0:N];
   lik_pkg::atan_flags_type           fl_ff [0:N];
   logic signed [lik_pkg::TQ_W-1:0]   tr_in, tr_ff, tc;
   logic                              yneg_ff;
   logic signed [lik_pkg::TQ_W-1:0]   tf;
   logic signed [lik_pkg::YAW_W-1:0]  angle_in, angle_ff;

   // magnitudes and special cases
   always_comb begin
      ax_in = x_val[W-1] ? W'(-x_val) : W'(x_val);
      ay_in = y_val[W-1] ? W'(-y_val) : W'(y_val);
      fl_in.x_neg = x_val[W-1];
      fl_in.y_neg = y_val[W-1];
      if (ay_in == '0)
         fl_in.kind = lik_pkg::KIND_Y_ZERO;
      else if (ax_in == '0)
         fl_in.kind = lik_pkg::KIND_X_ZERO;
      else
         fl_in.kind = lik_pkg::KIND_NORMAL;
   end

   // shift that brings the larger magnitude up to bit 40
   always_comb begin
      m     = (ax0_ff > ay0_ff) ? ax0_ff : ay0_ff;
      sh_in = '0;
      for (int b = 0; b < W; b++) begin
         if (m[b])
            sh_in = 6'(40 - b);
      end
   end

   // normalising shift
   always_comb begin
      wide_x = {41'b0, ax1_ff} << sh1_ff;
      wide_y = {41'b0, ay1_ff} << sh1_ff;
   end

   // CORDIC vectoring stages
   always_comb begin
      cx_in[0] = signed'(wide_x[lik_pkg::CORD_W-1:0]);
      cy_in[0] = signed'(wide_y[lik_pkg::CORD_W-1:0]);
      t_in[0]  = '0;
      for (int i = 0; i < N; i++) begin
         if (!cy_ff[i][lik_pkg::CORD_W-1]) begin
            cx_in[i+1] = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] - (cx_ff[i] >>> i);
            t_in[i+1]  = t_ff[i] + lik_pkg::atan_q30(i);
         end else begin
            cx_in[i+1] = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] + (cx_ff[i] >>> i);
            t_in[i+1]  = t_ff[i] - lik_pkg::atan_q30(i);
         end
      end
   end

   // clamp to the first quadrant, then reflect for negative x
   always_comb begin
      case (fl_ff[N].kind)
         lik_pkg::KIND_Y_ZERO: tc = '0;
         lik_pkg::KIND_X_ZERO: tc = lik_pkg::HALF_PI_Q30;
         default: begin
            if (t_ff[N] < 0)
               tc = '0;
            else if (t_ff[N] > lik_pkg::HALF_PI_Q30)
               tc = lik_pkg::HALF_PI_Q30;
            else
               tc = t_ff[N];
         end
      endcase
      tr_in = fl_ff[N].x_neg ? lik_pkg::PI_Q30 - tc : tc;
   end

   // round half up to Q.16 and apply the sign of y
   always_comb begin
      tf       = (tr_ff + 34'sd8192) >>> 14;
      angle_in = yneg_ff ? -lik_pkg::YAW_W'(tf) : lik_pkg::YAW_W'(tf);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax0_ff   <= ax_in;
         ay0_ff   <= ay_in;
         fl0_ff   <= fl_in;
         ax1_ff   <= ax0_ff;
         ay1_ff   <= ay0_ff;
         sh1_ff   <= sh_in;
         fl1_ff   <= fl0_ff;
         cx_ff[0] <= cx_in[0];
         cy_ff[0] <= cy_in[0];
         t_ff[0]  <= t_in[0];
         fl_ff[0] <= fl1_ff;
         for (int i = 0; i < N; i++) begin
            cx_ff[i+1] <= cx_in[i+1];
            cy_ff[i+1] <= cy_in[i+1];
            t_ff[i+1]  <= t_in[i+1];
            fl_ff[i+1] <= fl_ff[i];
         end
         tr_ff    <= tr_in;
         yneg_ff  <= fl_ff[N].y_neg;
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

`default_nettype wire

// File: rtl/lik_front.sv
// Front end: takes foot targets and forms the squared radii for the back end.
// Depends on lik_pkg.
`default_nettype none

module lik_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic signed [lik_pkg::POS_W-1:0] target_x,
   input  logic signed [lik_pkg::POS_W-1:0] target_y,
   input  logic signed [lik_pkg::POS_W-1:0] target_z,
   output logic                            q_push,
   output lik_pkg::entry_type              q_data,
   input  logic                            q_full
);

   localparam int P = lik_pkg::POS_W;

   logic                 en;
   logic                 v0_ff, v1_ff, v2_ff;
   logic signed [P-1:0]  x0_ff, y0_ff, z0_ff, x1_ff, y1_ff, z1_ff;
   logic [P-1:0]         ax, ay, az;
   logic [lik_pkg::SQ_W-1:0] sx_in, sy_in, sz_in, sx_ff, sy_ff, sz_ff;
   lik_pkg::entry_type   ent_in, ent_ff;

   // the whole front moves unless its last stage is blocked by the queue
   assign en   = !(v2_ff && q_full);
   assign full = !en;

   // absolute values and squares
   always_comb begin
      ax    = x0_ff[P-1] ? P'(-x0_ff) : P'(x0_ff);
      ay    = y0_ff[P-1] ? P'(-y0_ff) : P'(y0_ff);
      az    = z0_ff[P-1] ? P'(-z0_ff) : P'(z0_ff);
      sx_in = lik_pkg::SQ_W'(lik_pkg::SQ_W'(ax) * lik_pkg::SQ_W'(ax));
      sy_in = lik_pkg::SQ_W'(lik_pkg::SQ_W'(ay) * lik_pkg::SQ_W'(ay));
      sz_in = lik_pkg::SQ_W'(lik_pkg::SQ_W'(az) * lik_pkg::SQ_W'(az));
   end

   // horizontal and full squared distances
   always_comb begin
      ent_in.x   = x1_ff;
      ent_in.y   = y1_ff;
      ent_in.z   = z1_ff;
      ent_in.rsq = lik_pkg::SUMSQ_W'(sx_ff) + lik_pkg::SUMSQ_W'(sy_ff);
      ent_in.dsq = ent_in.rsq + lik_pkg::SUMSQ_W'(sz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= push;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff  <= target_x;
         y0_ff  <= target_y;
         z0_ff  <= target_z;
         x1_ff  <= x0_ff;
         y1_ff  <= y0_ff;
         z1_ff  <= z0_ff;
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         sz_ff  <= sz_in;
         ent_ff <= ent_in;
      end
   end

   assign q_push = v2_ff && en;
   assign q_data = ent_ff;

endmodule

`default_nettype wire

// File: rtl/lik_queue.sv
// Short queue that decouples the front end from the back end.
// Depends on lik_pkg.
`default_nettype none

module lik_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  lik_pkg::entry_type  wr_data,
   output logic                q_full,
   input  logic                rd_en,
   output lik_pkg::entry_type  rd_data,
   output logic                q_empty
);

   lik_pkg::entry_type             slot_ff [0:lik_pkg::QUEUE_DEPTH-1];
   logic [lik_pkg::QPTR_W-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [lik_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                           do_wr, do_rd;

   assign q_full  = cnt_ff == lik_pkg::QCNT_W'(lik_pkg::QUEUE_DEPTH);
   assign q_empty = cnt_ff == '0;
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = slot_ff[rp_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wp_in  = do_wr ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_rd ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + lik_pkg::QCNT_W'(do_wr) - lik_pkg::QCNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr)
         slot_ff[wp_ff] <= wr_data;
   end

endmodule

`default_nettype wire

// File: rtl/lik_back.sv
// Back end: square roots, link clamp, cosine division, arc cosines and the
// joint angle arithmetic, with the result register. Depends on lik_pkg,
// lik_sqrt, lik_divider and lik_atan2.
`default_nettype none

module lik_back (
   input  logic                               clock,
   input  logic                               reset,
   input  lik_pkg::entry_type                 q_data,
   input  logic                               q_empty,
   output logic                               q_pop,
   input  logic [lik_pkg::LINK_W-1:0]         upper_link,
   input  logic [lik_pkg::LINK_W-1:0]         lower_link,
   output logic                               empty,
   input  logic                               pop,
   output logic signed [lik_pkg::YAW_W-1:0]   yaw_angle,
   output logic signed [lik_pkg::HIP_W-1:0]   hip_angle,
   output logic [lik_pkg::KNEE_W-1:0]         knee_angle
);

   localparam int AW = lik_pkg::ATAN_IN_W;
   localparam int LW = lik_pkg::LINK_W;

   logic en;
   logic out_valid_ff;

   logic                              vld_ff   [0:lik_pkg::VALID_DLY-1];
   logic signed [lik_pkg::POS_W-1:0]  z_dl     [0:lik_pkg::Z_DLY-1];
   logic signed [lik_pkg::YAW_W-1:0]  yaw_dl   [0:lik_pkg::YAW_DLY-1];
   logic signed [lik_pkg::YAW_W-1:0]  alpha_dl [0:lik_pkg::ALPHA_DLY-1];
   logic signed [lik_pkg::COS_W-1:0]  cb_dl    [0:lik_pkg::COS_DLY-1];
   logic signed [lik_pkg::COS_W-1:0]  ck_dl    [0:lik_pkg::COS_DLY-1];

   logic [lik_pkg::ROOT_W-1:0]  r_root, d_root, sb_root, sk_root;
   logic signed [lik_pkg::YAW_W-1:0] yaw_raw, alpha_raw, beta_raw, kacos_raw;
   logic [LW-1:0]               l1e, l2e;
   logic [lik_pkg::DIST_W-1:0]  reach, d_in, d_ff;
   logic [35:0]                 l1sq_in, l1sq_ff, l2sq_in, l2sq_ff, l1l2_in, l1l2_ff;
   logic [37:0]                 dsq_in, dsq_ff;
   logic [36:0]                 l1d_in, l1d_ff;
   logic signed [lik_pkg::NUM_W-1:0] numb_in, numb_ff, numk_in, numk_ff;
   logic [lik_pkg::DEN_W-1:0]   denb_in, denb_ff, denk_in, denk_ff;
   logic signed [lik_pkg::COS_W-1:0] cb, ck;
   logic [32:0]                 csb_in, csb_ff, csk_in, csk_ff;
   logic [32:0]                 vb_in, vb_ff, vk_in, vk_ff;
   logic signed [lik_pkg::HIP_W-1:0] hip_in, hip_ff;
   logic [lik_pkg::KNEE_W-1:0]  knee_in, knee_ff;
   logic signed [lik_pkg::YAW_W-1:0] yaw_ff;

   // the back advances unless a finished result waits unread
   assign en    = !out_valid_ff || pop;
   assign q_pop = en && !q_empty;
   assign empty = !out_valid_ff;

   // horizontal radius and full distance
   lik_sqrt u_sqrt_r (
      .clock    (clock),
      .en       (en),
      .radicand (q_data.rsq),
      .root     (r_root)
   );

   lik_sqrt u_sqrt_d (
      .clock    (clock),
      .en       (en),
      .radicand (q_data.dsq),
      .root     (d_root)
   );

   lik_atan2 u_atan_yaw (
      .clock (clock),
      .en    (en),
      .y_val (AW'(q_data.y)),
      .x_val (AW'(q_data.x)),
      .angle (yaw_raw)
   );

   lik_atan2 u_atan_alpha (
      .clock (clock),
      .en    (en),
      .y_val (AW'(z_dl[lik_pkg::Z_DLY-1])),
      .x_val (signed'({1'b0, r_root})),
      .angle (alpha_raw)
   );

   // clamp the distance to the reach and to one LSB
   always_comb begin
      l1e   = (upper_link == '0) ? LW'(1) : upper_link;
      l2e   = (lower_link == '0) ? LW'(1) : lower_link;
      reach = {1'b0, l1e} + {1'b0, l2e};
      if (d_root > {1'b0, reach})
         d_in = reach;
      else
         d_in = d_root[lik_pkg::DIST_W-1:0];
      if (d_in == '0)
         d_in = lik_pkg::DIST_W'(1);
   end

   // products for both cosine laws
   always_comb begin
      l1sq_in = 36'(l1e) * 36'(l1e);
      l2sq_in = 36'(l2e) * 36'(l2e);
      l1l2_in = 36'(l1e) * 36'(l2e);
      dsq_in  = 38'(d_ff) * 38'(d_ff);
      l1d_in  = 37'(l1e) * 37'(d_ff);
   end

   // numerators and denominators
   always_comb begin
      numb_in = signed'(40'(l1sq_ff) + 40'(dsq_ff) - 40'(l2sq_ff));
      numk_in = signed'(40'(l1sq_ff) + 40'(l2sq_ff) - 40'(dsq_ff));
      denb_in = {l1d_ff, 1'b0};
      denk_in = {1'b0, l1l2_ff, 1'b0};
   end

   lik_divider u_div_b (
      .clock (clock),
      .en    (en),
      .num   (numb_ff),
      .den   (denb_ff),
      .quot  (cb)
   );

   lik_divider u_div_k (
      .clock (clock),
      .en    (en),
      .num   (numk_ff),
      .den   (denk_ff),
      .quot  (ck)
   );

   // sine magnitude squared: 1 - c^2 in Q.32
   always_comb begin
      csb_in = 33'(36'(cb) * 36'(cb));
      csk_in = 33'(36'(ck) * 36'(ck));
      vb_in  = 33'h1_0000_0000 - csb_ff;
      vk_in  = 33'h1_0000_0000 - csk_ff;
   end

   lik_sqrt u_sqrt_sb (
      .clock    (clock),
      .en       (en),
      .radicand ({7'b0, vb_ff}),
      .root     (sb_root)
   );

   lik_sqrt u_sqrt_sk (
      .clock    (clock),
      .en       (en),
      .radicand ({7'b0, vk_ff}),
      .root     (sk_root)
   );

   lik_atan2 u_atan_beta (
      .clock (clock),
      .en    (en),
      .y_val (signed'({1'b0, sb_root})),
      .x_val (AW'(cb_dl[lik_pkg::COS_DLY-1])),
      .angle (beta_raw)
   );

   lik_atan2 u_atan_knee (
      .clock (clock),
      .en    (en),
      .y_val (signed'({1'b0, sk_root})),
      .x_val (AW'(ck_dl[lik_pkg::COS_DLY-1])),
      .angle (kacos_raw)
   );

   // joint angles
   always_comb begin
      hip_in  = lik_pkg::HIP_W'(alpha_dl[lik_pkg::ALPHA_DLY-1])
                - lik_pkg::HIP_W'(beta_raw);
      knee_in = lik_pkg::KNEE_W'(lik_pkg::PI_F - lik_pkg::HIP_W'(kacos_raw));
   end

   // valid tracking and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < lik_pkg::VALID_DLY; k++)
            vld_ff[k] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= !q_empty;
         for (int k = 1; k < lik_pkg::VALID_DLY; k++)
            vld_ff[k] <= vld_ff[k-1];
         out_valid_ff <= vld_ff[lik_pkg::VALID_DLY-1];
      end
   end

   // datapath registers and alignment delays
   always_ff @(posedge clock) begin
      if (en) begin
         z_dl[0] <= q_data.z;
         for (int k = 1; k < lik_pkg::Z_DLY; k++)
            z_dl[k] <= z_dl[k-1];
         yaw_dl[0] <= yaw_raw;
         for (int k = 1; k < lik_pkg::YAW_DLY; k++)
            yaw_dl[k] <= yaw_dl[k-1];
         alpha_dl[0] <= alpha_raw;
         for (int k = 1; k < lik_pkg::ALPHA_DLY; k++)
            alpha_dl[k] <= alpha_dl[k-1];
         cb_dl[0] <= cb;
         ck_dl[0] <= ck;
         for (int k = 1; k < lik_pkg::COS_DLY; k++) begin
            cb_dl[k] <= cb_dl[k-1];
            ck_dl[k] <= ck_dl[k-1];
         end
         d_ff    <= d_in;
         l1sq_ff <= l1sq_in;
         l2sq_ff <= l2sq_in;
         l1l2_ff <= l1l2_in;
         dsq_ff  <= dsq_in;
         l1d_ff  <= l1d_in;
         numb_ff <= numb_in;
         numk_ff <= numk_in;
         denb_ff <= denb_in;
         denk_ff <= denk_in;
         csb_ff  <= csb_in;
         csk_ff  <= csk_in;
         vb_ff   <= vb_in;
         vk_ff   <= vk_in;
         yaw_ff  <= yaw_dl[lik_pkg::YAW_DLY-1];
         hip_ff  <= hip_in;
         knee_ff <= knee_in;
      end
   end

   assign yaw_angle  = yaw_ff;
   assign hip_angle  = hip_ff;
   assign knee_angle = knee_ff;

endmodule

`default_nettype wire

// File: rtl/leg_inverse_kinematics_core.sv
// Leg inverse kinematics core: foot target (x, y, z) in, yaw/hip/knee angles out.
// A target passes through the front end, the queue and the back end in that order.
// Throughput one target per cycle while the queue is not full and no result waits unread;
// every unit (square roots, dividers, CORDICs) is fully pipelined.
// Reset (synchronous) empties front, queue and back and sets both links to 6554.
// Depends on lik_pkg, lik_front, lik_queue and lik_back.
`default_nettype none

module leg_inverse_kinematics_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic signed [lik_pkg::POS_W-1:0]   req_target_x,
   input  logic signed [lik_pkg::POS_W-1:0]   req_target_y,
   input  logic signed [lik_pkg::POS_W-1:0]   req_target_z,
   output logic                               empty,
   input  logic                               pop,
   output logic signed [lik_pkg::YAW_W-1:0]   rsp_yaw_angle,
   output logic signed [lik_pkg::HIP_W-1:0]   rsp_hip_angle,
   output logic [lik_pkg::KNEE_W-1:0]         rsp_knee_angle,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   logic [lik_pkg::LINK_W-1:0] upper_ff, upper_in, lower_ff, lower_in;
   logic                       wr;
   logic                       q_push, q_full, q_pop, q_empty;
   lik_pkg::entry_type         q_wr_data, q_rd_data;

   // configuration registers
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_comb begin
      upper_in = upper_ff;
      lower_in = lower_ff;
      if (wr) begin
         case (paddr[2])
            lik_pkg::REG_UPPER: upper_in = pwdata[lik_pkg::LINK_W-1:0];
            lik_pkg::REG_LOWER: lower_in = pwdata[lik_pkg::LINK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= lik_pkg::LINK_RESET;
         lower_ff <= lik_pkg::LINK_RESET;
      end else begin
         upper_ff <= upper_in;
         lower_ff <= lower_in;
      end
   end

   assign prdata = (paddr[2] == lik_pkg::REG_LOWER) ? 32'(lower_ff) : 32'(upper_ff);

   lik_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .target_x (req_target_x),
      .target_y (req_target_y),
      .target_z (req_target_z),
      .q_push   (q_push),
      .q_data   (q_wr_data),
      .q_full   (q_full)
   );

   lik_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .q_empty (q_empty)
   );

   lik_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_data     (q_rd_data),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .upper_link (upper_ff),
      .lower_link (lower_ff),
      .empty      (empty),
      .pop        (pop),
      .yaw_angle  (rsp_yaw_angle),
      .hip_angle  (rsp_hip_angle),
      .knee_angle (rsp_knee_angle)
   );

endmodule

`default_nettype wire
